@@ design/ca5_pkg.sv @@
// ----------------------------------------------------------------------------
// ca5_pkg
// Shared types and constants for the five-neighbour automaton cycle checker.
// ----------------------------------------------------------------------------
package ca5_pkg;

	localparam int RULE_W = 32;
	localparam int CODE_W = 5;
	localparam int CNT_W  = 4;

	typedef logic [RULE_W-1:0] rule_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam cnt_t CNT_RESET = cnt_t'(8);

endpackage

@@ design/ca5_if.sv @@
// ----------------------------------------------------------------------------
// ca5 channel interfaces
// Valid/ready channels for rule beats in and verdict beats out.
// ----------------------------------------------------------------------------
interface ca5_in_if;
	logic           valid;
	logic           ready;
	ca5_pkg::rule_t rule;

	modport source (output valid, output rule, input ready);
	modport sink   (input valid, input rule, output ready);
endinterface

interface ca5_out_if;
	logic valid;
	logic ready;
	logic has_long_cycle;

	modport source (output valid, output has_long_cycle, input ready);
	modport sink   (input valid, input has_long_cycle, output ready);
endinterface

@@ design/ca5_ram.sv @@
// ----------------------------------------------------------------------------
// ca5_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ca5_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/ca5_step.sv @@
// ----------------------------------------------------------------------------
// ca5_step
// One automaton update: every cell looks up its five-cell neighbourhood code.
// ----------------------------------------------------------------------------
module ca5_step #(
	parameter int SW = 12
) (
	input  ca5_pkg::rule_t rule,
	input  logic [SW-1:0]  mask,
	input  logic [SW-1:0]  cur,
	output logic [SW-1:0]  nxt
);
	import ca5_pkg::*;

	logic [SW+3:0] pad;

	// Two zero cells on each side model the null boundary.
	assign pad = {2'b00, cur, 2'b00};

	always_comb begin
		for (int b = 0; b < SW; b++) begin
			nxt[b] = rule[pad[b +: CODE_W]] & mask[b];
		end
	end

endmodule

@@ design/ca5_null_boundary_multicycle_check.sv @@
// ----------------------------------------------------------------------------
// ca5_null_boundary_multicycle_check
// Reports whether a five-neighbour null-boundary automaton has a cycle longer
// than one step, by walking the trajectory of every start state.
// ----------------------------------------------------------------------------
// One rule beat is taken at a time and gives one verdict beat. With n cells in
// use (the register, limited to MAX_CELLS), each start state first clears the
// 2^n entries of the seen bitmap, then marks the start, then spends a read state
// and a check state on every step of the trajectory up to and including the
// first revisit, because the bitmap is a single RAM with a registered read and
// the step unit handles one automaton update per loop. Starts run in order from
// zero until a long cycle is found or all 2^n are done; the done state then hands
// the verdict to the output register once no earlier verdict is still pending.
// The input is ready again as soon as the verdict is registered, even while that
// verdict still waits to be taken. The bitmap is cleared before every start, so
// no separate pass is needed after reset.
module ca5_null_boundary_multicycle_check #(
	parameter int MAX_CELLS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	ca5_in_if.sink             item,
	ca5_out_if.source          result,
	input  logic               cfg_we,
	input  ca5_pkg::cnt_t      cfg_wdata
);
	import ca5_pkg::*;

	localparam int SW    = MAX_CELLS;
	localparam int DEPTH = 1 << SW;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_MARK  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]    state_q;
	cnt_t          cnt_q;
	rule_t         rule_q;
	logic [SW-1:0] mask_q;
	logic [SW-1:0] mask_d;
	logic [SW-1:0] clr_q;
	logic [SW-1:0] start_q;
	logic [SW-1:0] cur_q;
	logic [SW-1:0] nxt_q;
	logic          found_q;
	logic          res_vld_q;
	logic          res_q;

	logic [SW-1:0] step_in;
	logic [SW-1:0] step_out;

	logic          ram_we;
	logic [SW-1:0] ram_waddr;
	logic          ram_wdata;
	logic          ram_re;
	logic          ram_rdata;

	// A count above the built width simply enables every cell.
	always_comb begin
		for (int b = 0; b < SW; b++) begin
			mask_d[b] = (b < int'(cnt_q));
		end
	end

	assign item.ready     = (state_q == ST_IDLE);
	assign result.valid   = res_vld_q;
	assign result.has_long_cycle = res_q;

	assign step_in = (state_q == ST_MARK) ? start_q : nxt_q;

	ca5_step #(.SW(SW)) u_step (
		.rule (rule_q),
		.mask (mask_q),
		.cur  (step_in),
		.nxt  (step_out)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = nxt_q;
		ram_wdata = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = 1'b0;
			end
			ST_MARK: begin
				ram_we    = 1'b1;
				ram_waddr = start_q;
			end
			ST_CHECK: begin
				ram_we    = !ram_rdata;
			end
			default: begin
				ram_we    = 1'b0;
			end
		endcase
	end

	assign ram_re = (state_q == ST_READ);

	ca5_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_seen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (nxt_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_RESET;
		end else if (cfg_we) begin
			cnt_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			res_vld_q <= 1'b0;
		end else begin
			// In the done state the verdict register is refilled below instead.
			if (result.valid && result.ready && state_q != ST_DONE) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						state_q <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					if (clr_q == mask_q) begin
						state_q <= ST_MARK;
					end
				end
				ST_MARK: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!ram_rdata) begin
						state_q <= ST_READ;
					end else if (cur_q != nxt_q || start_q == mask_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_CLEAR;
					end
				end
				ST_DONE: begin
					if (!res_vld_q || result.ready) begin
						res_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rule_q  <= item.rule;
				mask_q  <= mask_d;
				clr_q   <= '0;
				start_q <= '0;
			end
			ST_CLEAR: begin
				clr_q <= clr_q + SW'(1);
			end
			ST_MARK: begin
				cur_q <= start_q;
				nxt_q <= step_out;
			end
			ST_CHECK: begin
				if (!ram_rdata) begin
					cur_q <= nxt_q;
					nxt_q <= step_out;
				end else begin
					// A revisit of a state that maps to itself is harmless.
					found_q <= (cur_q != nxt_q);
					clr_q   <= '0;
					start_q <= start_q + SW'(1);
				end
			end
			ST_DONE: begin
				if (!res_vld_q || result.ready) begin
					res_q <= found_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_q) |-> $past(state_q) == ST_DONE)
		else $error("verdict appeared without a finished search");

	a_pending_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && res_vld_q && !result.ready |=>
			state_q == ST_DONE && res_vld_q)
		else $error("pending verdict overwritten");

	a_state_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_CHECK) |->
			((nxt_q & ~mask_q) == '0 && (cur_q & ~mask_q) == '0))
		else $error("trajectory state outside the enabled cells");

	a_no_rewrite_seen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK && ram_rdata |-> !ram_we)
		else $error("seen entry written on a revisit");

endmodule

@@ tb/sv/ca5_null_boundary_multicycle_check_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ca5_null_boundary_multicycle_check_test
// Drives rule beats through the cycle checker under several cell counts and
// compares every verdict beat with a software walk of all trajectories.
// ----------------------------------------------------------------------------
module ca5_null_boundary_multicycle_check_test;
	import ca5_pkg::*;

	localparam int MAX_CELLS = 12;
	localparam int STATE_COUNT = 1 << MAX_CELLS;
	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 6;
	localparam int TAIL_CYCLES = 50;
	localparam longint LIMIT_NS = 400_000_000;

	typedef logic [MAX_CELLS-1:0] ca_state_t;

	typedef enum logic [1:0] {
		JOB_RULE,
		JOB_CELLS,
		JOB_DRAIN
	} job_kind_t;

	typedef struct {
		job_kind_t kind;
		rule_t     rule;
		cnt_t      cells;
	} job_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cnt_t cfg_wdata;

	ca5_in_if  in_ch ();
	ca5_out_if out_ch ();

	ca5_null_boundary_multicycle_check #(
		.MAX_CELLS(MAX_CELLS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (in_ch),
		.result   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// Predictor state: its own copy of the cell count and of the seen bitmap.
	cnt_t model_cells;
	bit   seen_map [0:STATE_COUNT-1];

	job_t jobs[$];
	logic verdicts[$];
	int   mismatches = 0;
	int   send_wait = 0;
	int   send_calm = 0;
	int   recv_wait = 0;
	int   recv_calm = 0;

	function automatic ca_state_t ca5_next(rule_t rule, ca_state_t s, int n);
		logic [MAX_CELLS+3:0] pad;
		logic [CODE_W-1:0]    code;
		ca_state_t            nxt;
		pad = {2'b00, s, 2'b00};
		nxt = '0;
		for (int b = 0; b < n; b++) begin
			code = pad[b +: CODE_W];
			nxt[b] = rule[code];
		end
		return nxt;
	endfunction

	function automatic logic long_cycle_verdict(rule_t rule, cnt_t cells);
		int        n;
		int        total;
		int        start;
		int        j;
		int        k;
		ca_state_t cur;
		ca_state_t nxt;
		ca_state_t mask;
		bit        found;
		bit        stop;
		n = (cells > MAX_CELLS) ? MAX_CELLS : int'(cells);
		total = 1 << n;
		mask = ca_state_t'(total - 1);
		found = 1'b0;
		for (start = 0; start < total && !found; start++) begin
			for (k = 0; k < total; k++) seen_map[k] = 1'b0;
			cur = start[MAX_CELLS-1:0];
			seen_map[cur] = 1'b1;
			nxt = ca5_next(rule, cur, n) & mask;
			stop = 1'b0;
			// The first revisit ends the walk; only a non-fixed revisit counts.
			for (j = 0; j < total && !stop; j++) begin
				if (!seen_map[nxt]) begin
					seen_map[nxt] = 1'b1;
					cur = nxt;
					nxt = ca5_next(rule, cur, n) & mask;
				end else begin
					found = (cur != nxt);
					stop = 1'b1;
				end
			end
		end
		return found;
	endfunction

	// Mostly uniform waits, with occasional runs of back-to-back beats.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 7) == 0) begin
			calm = $urandom_range(4, 10);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	function automatic rule_t random_rule();
		case ($urandom_range(0, 2))
			0: return $urandom;
			1: return $urandom & $urandom & $urandom;
			default: return $urandom | $urandom | $urandom;
		endcase
	endfunction

	// With the full width, zero steps to all ones and all ones back to zero,
	// so the very first start finds a two-step cycle and the run stays short.
	function automatic rule_t quick_rule(rule_t r);
		return (r & 32'h2FFF_7F7F) | 32'h0000_0001;
	endfunction

	task automatic add_rule(rule_t r);
		job_t j;
		j.kind = JOB_RULE;
		j.rule = r;
		j.cells = '0;
		jobs.push_back(j);
	endtask

	task automatic add_cells(cnt_t c);
		job_t j;
		j.kind = JOB_CELLS;
		j.rule = '0;
		j.cells = c;
		jobs.push_back(j);
	endtask

	task automatic add_drain();
		job_t j;
		j.kind = JOB_DRAIN;
		j.rule = '0;
		j.cells = '0;
		jobs.push_back(j);
	endtask

	// Sender: presents rule beats and performs register writes while idle.
	always @(posedge clk) begin : drive
		logic nv;
		logic nwe;
		job_t j;
		if (arst_n) begin
			nv = in_ch.valid;
			nwe = 1'b0;
			if (in_ch.valid && in_ch.ready) begin
				verdicts.push_back(long_cycle_verdict(in_ch.rule, model_cells));
				nv = 1'b0;
				send_wait = draw_wait(send_calm);
			end
			if (!nv) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (jobs.size() > 0) begin
					j = jobs[0];
					case (j.kind)
						JOB_RULE: begin
							nv = 1'b1;
							in_ch.rule <= j.rule;
							jobs.pop_front();
						end
						JOB_CELLS: begin
							if (verdicts.size() == 0) begin
								nwe = 1'b1;
								cfg_wdata <= j.cells;
								model_cells = j.cells;
								jobs.pop_front();
							end
						end
						default: begin
							if (verdicts.size() == 0) jobs.pop_front();
						end
					endcase
				end
			end
			in_ch.valid <= nv;
			cfg_we <= nwe;
		end
	end

	// Receiver: stalls between verdict beats and checks each one.
	always @(posedge clk) begin : watch
		logic want;
		logic exp_v;
		if (arst_n) begin
			want = out_ch.ready;
			if (out_ch.valid && out_ch.ready) begin
				if (verdicts.size() == 0) begin
					$error("has_long_cycle: no beat expected, actual %0b",
						out_ch.has_long_cycle);
					mismatches++;
				end else begin
					exp_v = verdicts.pop_front();
					if (exp_v !== out_ch.has_long_cycle) begin
						$error("has_long_cycle: expected %0b, actual %0b",
							exp_v, out_ch.has_long_cycle);
						mismatches++;
					end
				end
				recv_wait = draw_wait(recv_calm);
				want = (recv_wait == 0);
			end else if (!want) begin
				if (recv_wait > 0) recv_wait--;
				want = (recv_wait == 0);
			end
			out_ch.ready <= want;
		end
	end

	initial begin
		int   ph;
		cnt_t c;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.rule = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		model_cells = CNT_RESET;
		for (int k = 0; k < STATE_COUNT; k++) seen_map[k] = 1'b0;

		// Reset value of the cell count first, then the extremes.
		add_rule(32'h0000_0000);
		add_rule(32'hFFFF_FFFF);
		add_rule(32'h0000_0001);
		add_cells(cnt_t'(1));
		add_rule(32'h0000_0000);
		add_rule(32'hFFFF_FFFF);
		add_rule(32'h0000_0001);
		add_rule(32'h0000_0010);
		// No cells at all: the single empty state is a fixed point.
		add_cells(cnt_t'(0));
		add_rule(32'hFFFF_FFFF);
		add_rule(32'h5555_5555);
		add_cells(cnt_t'(MAX_CELLS));
		add_rule(32'h0000_0001);
		add_rule(quick_rule($urandom));
		// Counts above the built maximum saturate to it.
		add_cells(cnt_t'(15));
		add_rule(quick_rule($urandom));
		add_rule(32'h2FFF_7F7F);
		add_cells(cnt_t'(3));
		add_rule(32'hAAAA_AAAA);
		add_rule(32'h0F0F_F0F0);

		for (ph = 0; ph < 7; ph++) begin
			c = cnt_t'((ph == 0) ? 1 : $urandom_range(1, 6));
			add_cells(c);
			repeat (13) add_rule(random_rule());
			if (ph == 3) begin
				add_drain();
				repeat (3) add_rule(random_rule());
			end
		end
		add_cells(cnt_t'(7));
		repeat (3) add_rule(random_rule());
		add_cells(cnt_t'($urandom_range(MAX_CELLS, 15)));
		repeat (4) add_rule(quick_rule(random_rule()));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (jobs.size() != 0 || in_ch.valid || verdicts.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

endmodule
